FILE: rtl/rgb_box_mean_filter_macros.svh
// Assertion macros shared by the checker of the RGB box mean filter.
// Depends on nothing; expects signals named clk and rst at the place of use.
`ifndef RGB_BOX_MEAN_FILTER_MACROS_SVH
`define RGB_BOX_MEAN_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BMF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmf checker: property failed");

// Next-cycle implication, disabled while reset is high.
`define BMF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmf checker: property failed");

`endif

FILE: rtl/bmf_pkg.sv
// Package of the RGB box mean filter: register codes, fixed field widths
// and the command and status bundles between controller and datapath.
package bmf_pkg;

  localparam int PIX_W        = 8;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic setup_a;
    logic setup_b;
    logic setup_c;
    logic read;
    logic accum;
    logic div_start;
    logic div_step;
    logic load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ignore;
    logic emit;
    logic scan_last;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/bmf_if.sv
// Channel interfaces of the RGB box mean filter: pixel in, pixel out and
// the configuration write channel. Depends on bmf_pkg.
interface bmf_pix_in_if import bmf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;
  modport source (output valid, action, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, action, red_in, green_in, blue_in, output ready);
endinterface

interface bmf_pix_out_if import bmf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] blue_out;
  logic             last_pixel;
  modport source (output valid, red_out, green_out, blue_out, last_pixel, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, last_pixel, output ready);
endinterface

interface bmf_cfg_if import bmf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/bmf_ctrl.sv
// Controller of the RGB box mean filter: sequences accept, window setup,
// window scan, division and result load. Depends on bmf_pkg.
module bmf_ctrl import bmf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SA   = 4'd1;
  localparam logic [3:0] ST_SB   = 4'd2;
  localparam logic [3:0] ST_SC   = 4'd3;
  localparam logic [3:0] ST_RD   = 4'd4;
  localparam logic [3:0] ST_AC   = 4'd5;
  localparam logic [3:0] ST_DS   = 4'd6;
  localparam logic [3:0] ST_DV   = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && !stat.ignore && stat.emit) begin
          state_next = ST_SA;
        end
      end
      ST_SA: begin
        cmd.setup_a = 1'b1;
        state_next  = ST_SB;
      end
      ST_SB: begin
        cmd.setup_b = 1'b1;
        state_next  = ST_SC;
      end
      ST_SC: begin
        cmd.setup_c = 1'b1;
        state_next  = ST_RD;
      end
      ST_RD: begin
        cmd.read   = 1'b1;
        state_next = ST_AC;
      end
      ST_AC: begin
        cmd.accum  = 1'b1;
        state_next = stat.scan_last ? ST_DS : ST_RD;
      end
      ST_DS: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DV;
      end
      ST_DV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/bmf_dp.sv
// Datapath of the RGB box mean filter: size registers, pixel ring memory,
// position counters, window accumulators and a restoring divider.
// Depends on bmf_pkg; driven by bmf_ctrl.
module bmf_dp import bmf_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 4096,
  parameter int WINDOW_HALF = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic                  action,
  input  logic [PIX_W-1:0]      red_in,
  input  logic [PIX_W-1:0]      green_in,
  input  logic [PIX_W-1:0]      blue_in,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      red_out,
  output logic [PIX_W-1:0]      green_out,
  output logic [PIX_W-1:0]      blue_out,
  output logic                  last_pixel
);

  localparam int H     = WINDOW_HALF;
  localparam int RING  = 2 * H * (MAX_WIDTH + 1);
  localparam int AW    = $clog2(RING);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + RING + 1);
  localparam int HBW   = $clog2(H + 1);
  localparam int NW    = $clog2(2 * H + 1);
  localparam int CNTW  = $clog2(4 * H * H + 1);
  localparam int SW    = PIX_W + CNTW;
  localparam int DCW   = $clog2(SW + 1);

  function automatic logic [CNTW+SW-1:0] div_bit(input logic [CNTW-1:0] rem,
                                                 input logic [SW-1:0]   dvd,
                                                 input logic [CNTW-1:0] d);
    logic [CNTW:0]   tmp;
    logic [CNTW-1:0] rem_n;
    logic            q;
    tmp = {rem, dvd[SW-1]};
    q   = (tmp >= {1'b0, d});
    rem_n = q ? CNTW'(tmp - {1'b0, d}) : CNTW'(tmp);
    return {rem_n, dvd[SW-2:0], q};
  endfunction

  // Size registers and clamped sizes.
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  logic [WW-1:0]           w;
  logic [HW-1:0]           h;
  logic [PW-1:0]           total;
  logic [PW-1:0]           lag;

  always_comb begin
    if (width_reg == '0) begin
      w = WW'(1);
    end else if (32'(width_reg) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(width_reg);
    end
    if (height_reg == '0) begin
      h = HW'(1);
    end else if (32'(height_reg) > MAX_HEIGHT) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(height_reg);
    end
    total = PW'(w) * PW'(h);
    lag   = PW'(H - 1) * (PW'(w) + PW'(1));
  end

  // Positions and ring pointer.
  logic [PW-1:0] in_pos;
  logic [AW-1:0] wp;
  logic [AW-1:0] cur_addr;
  logic [WW-1:0] ox;
  logic [HW-1:0] oy;
  logic          in_frame;
  logic          cfg_hit;
  logic          last_now;

  assign in_frame = (in_pos < total);
  assign cfg_hit  = cfg_valid &&
                    (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);
  assign last_now = (ox == w - WW'(1)) && (oy == h - HW'(1));

  // Window geometry.
  logic [HBW-1:0]  mx;
  logic [HBW-1:0]  my;
  logic [NW-1:0]   nc;
  logic [NW-1:0]   nr;
  logic [NW-1:0]   cc;
  logic [NW-1:0]   rc;
  logic [CNTW-1:0] cnt;
  logic [AW:0]     back;
  logic [AW-1:0]   step;
  logic [AW-1:0]   addr;
  logic [WW-1:0]   rx;
  logic [HW-1:0]   ry;
  logic            col_last;
  logic [AW:0]     addr_sum;
  logic [AW-1:0]   addr_next;

  always_comb begin
    rx = w - WW'(1) - ox;
    if (32'(rx) > H - 1) begin
      rx = WW'(H - 1);
    end
    ry = h - HW'(1) - oy;
    if (32'(ry) > H - 1) begin
      ry = HW'(H - 1);
    end
    col_last  = (cc == nc - NW'(1));
    addr_sum  = {1'b0, addr} + (col_last ? {1'b0, step} : (AW+1)'(1));
    addr_next = (addr_sum >= (AW+1)'(RING)) ? AW'(addr_sum - (AW+1)'(RING))
                                            : AW'(addr_sum);
  end

  // Memory.
  logic [3*PIX_W-1:0] mem [RING];
  logic [3*PIX_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (cmd.accept && !stat.ignore && in_frame) begin
      mem[wp] <= {red_in, green_in, blue_in};
    end
    if (cmd.read) begin
      rdata <= mem[addr];
    end
  end

  // Sums and divider.
  logic [SW-1:0]   sum_r;
  logic [SW-1:0]   sum_g;
  logic [SW-1:0]   sum_b;
  logic [CNTW-1:0] rem_r;
  logic [CNTW-1:0] rem_g;
  logic [CNTW-1:0] rem_b;
  logic [DCW-1:0]  dcnt;

  assign stat.ignore    = in_frame && action;
  assign stat.emit      = (in_pos >= lag);
  assign stat.scan_last = col_last && (rc == nr - NW'(1));
  assign stat.div_done  = (dcnt == DCW'(SW - 1));
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
      in_pos     <= '0;
      wp         <= '0;
      ox         <= '0;
      oy         <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_index == REG_IMAGE_WIDTH) begin
        width_reg <= cfg_data[WIDTH_REG_W-1:0];
      end
      if (cfg_valid && cfg_index == REG_IMAGE_HEIGHT) begin
        height_reg <= cfg_data[HEIGHT_REG_W-1:0];
      end
      if (cfg_hit) begin
        in_pos <= '0;
        wp     <= '0;
        ox     <= '0;
        oy     <= '0;
      end else if (cmd.accept && !stat.ignore) begin
        in_pos <= in_pos + PW'(1);
        wp     <= (wp == AW'(RING - 1)) ? '0 : wp + AW'(1);
      end else if (cmd.load) begin
        out_valid <= 1'b1;
        if (last_now) begin
          in_pos <= '0;
          wp     <= '0;
          ox     <= '0;
          oy     <= '0;
        end else if (ox == w - WW'(1)) begin
          ox <= '0;
          oy <= oy + HW'(1);
        end else begin
          ox <= ox + WW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_addr <= wp;
    end
    if (cmd.setup_a) begin
      mx <= (32'(ox) < H) ? HBW'(ox) : HBW'(H);
      my <= (32'(oy) < H) ? HBW'(oy) : HBW'(H);
      nc <= NW'(rx) + ((32'(ox) < H) ? NW'(ox) : NW'(H)) + NW'(1);
      nr <= NW'(ry) + ((32'(oy) < H) ? NW'(oy) : NW'(H)) + NW'(1);
    end
    if (cmd.setup_b) begin
      back <= (AW+1)'(lag) + (AW+1)'(my) * (AW+1)'(w) + (AW+1)'(mx);
      cnt  <= CNTW'(nr) * CNTW'(nc);
      step <= AW'(w) + AW'(1) - AW'(nc);
    end
    if (cmd.setup_c) begin
      addr  <= ({1'b0, cur_addr} >= back) ? AW'({1'b0, cur_addr} - back)
                                          : AW'({1'b0, cur_addr} + (AW+1)'(RING) - back);
      cc    <= '0;
      rc    <= '0;
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
    end
    if (cmd.accum) begin
      sum_r <= sum_r + SW'(rdata[3*PIX_W-1:2*PIX_W]);
      sum_g <= sum_g + SW'(rdata[2*PIX_W-1:PIX_W]);
      sum_b <= sum_b + SW'(rdata[PIX_W-1:0]);
      addr  <= addr_next;
      if (col_last) begin
        cc <= '0;
        rc <= rc + NW'(1);
      end else begin
        cc <= cc + NW'(1);
      end
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      rem_g <= '0;
      rem_b <= '0;
      dcnt  <= '0;
    end
    if (cmd.div_step) begin
      {rem_r, sum_r} <= div_bit(rem_r, sum_r, cnt);
      {rem_g, sum_g} <= div_bit(rem_g, sum_g, cnt);
      {rem_b, sum_b} <= div_bit(rem_b, sum_b, cnt);
      dcnt           <= dcnt + DCW'(1);
    end
    if (cmd.load) begin
      red_out    <= sum_r[PIX_W-1:0];
      green_out  <= sum_g[PIX_W-1:0];
      blue_out   <= sum_b[PIX_W-1:0];
      last_pixel <= last_now;
    end
  end

endmodule

FILE: rtl/rgb_box_mean_filter.sv
// Top level of the RGB box mean filter: joins controller and datapath to
// the pixel and configuration channels. Depends on bmf_pkg, bmf_if,
// bmf_ctrl and bmf_dp.

// The block takes RGB pixels in raster order and returns, for each pixel,
// the truncated mean of every channel over a window of 2*WINDOW_HALF rows
// and columns (from WINDOW_HALF before to WINDOW_HALF-1 after the pixel),
// clipped to the image and divided by the number of pixels inside it.
// Results lag the input by (WINDOW_HALF-1)*(width+1) beats, so after the
// final pixel the source sends that many drain beats (action set) to flush
// the last results; drain beats sent before the frame is complete are taken
// and dropped. A beat that yields a result passes through the accept, the
// setup steps setup_a, setup_b and setup_c, a read of the pixel ring and
// an accumulate for each window pixel, a start step and then one step for
// each of the 15 bits of the window sum in the restoring dividers (one per
// channel), and a load of the output register, which waits while a stalled
// result still holds the output.
// The next beat is accepted while a finished result waits on the output.
// Writing either size register restarts the frame.
module rgb_box_mean_filter import bmf_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 4096,
  parameter int WINDOW_HALF = 5
) (
  input logic          clk,
  input logic          rst,
  bmf_pix_in_if.sink   pix_in,
  bmf_pix_out_if.source pix_out,
  bmf_cfg_if.sink      cfg
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  // The source must send configuration writes only while the block is idle; the block does not enforce this.
  assign cfg.ready    = 1'b1;
  assign pix_in.ready = in_ready;

  bmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix_in.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bmf_dp #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .WINDOW_HALF (WINDOW_HALF)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .action     (pix_in.action),
    .red_in     (pix_in.red_in),
    .green_in   (pix_in.green_in),
    .blue_in    (pix_in.blue_in),
    .cfg_valid  (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .out_valid  (pix_out.valid),
    .out_ready  (pix_out.ready),
    .red_out    (pix_out.red_out),
    .green_out  (pix_out.green_out),
    .blue_out   (pix_out.blue_out),
    .last_pixel (pix_out.last_pixel)
  );

endmodule

FILE: rtl/bmf_checker.sv
// Port-level checker of the RGB box mean filter and its bind statement.
// Depends on bmf_pkg and rgb_box_mean_filter_macros.svh.
`include "rgb_box_mean_filter_macros.svh"

module bmf_checker import bmf_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] red_out,
  input logic [PIX_W-1:0] green_out,
  input logic [PIX_W-1:0] blue_out,
  input logic             last_pixel,
  input logic             cfg_valid,
  input logic             cfg_ready
);

  // A stalled result keeps its beat.
  `BMF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(last_pixel))
  // The configuration channel never stalls.
  `BMF_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)
  // A result is loaded only while input is held off.
  `BMF_ASSERT_NOW(a_load_busy, $rose(out_valid), !$past(in_ready))
  // No result appears in the cycle right after an input beat.
  `BMF_ASSERT_NEXT(a_no_instant, in_valid && in_ready, !$rose(out_valid))

endmodule

bind rgb_box_mean_filter bmf_checker u_bmf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pix_in.valid),
  .in_ready   (pix_in.ready),
  .out_valid  (pix_out.valid),
  .out_ready  (pix_out.ready),
  .red_out    (pix_out.red_out),
  .green_out  (pix_out.green_out),
  .blue_out   (pix_out.blue_out),
  .last_pixel (pix_out.last_pixel),
  .cfg_valid  (cfg.valid),
  .cfg_ready  (cfg.ready)
);

FILE: tb/rgb_box_mean_filter_tb.sv
// Self-checking testbench of the RGB box mean filter: frames of random and
// extreme pixels, size register changes, and random gaps on both channels.
// Depends on bmf_pkg, bmf_if and the rgb_box_mean_filter top level.

module rgb_box_mean_filter_tb;
  import bmf_pkg::*;

  localparam int MAX_W      = 1024;
  localparam int MAX_H      = 4096;
  localparam int HALF       = 5;
  localparam int WATCHDOG   = 20000;
  // This pause covers any result that is still being
  // worked out.
  localparam int SETTLE     = 400;
  localparam int ITEM_GOAL  = 1350;
  // A frame cut short sends at most this many beats, not counting the noise drain beats.
  localparam int CUT_MAX    = 200;

  // Indexes with no register behind them; a write there changes nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             last;
  } mean_pixel_t;

  // Tracks the frame position and the stored pixels, and holds the window
  // means that the block still owes.
  class box_mean_scoreboard;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    int unsigned             frame_pos;
    logic [3*PIX_W-1:0]      frame_px[int unsigned];
    mean_pixel_t             owed_means[$];
    int                      errors;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      frame_pos  = 0;
      errors     = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg = val[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_reg = val[HEIGHT_REG_W-1:0];
        default: return;
      endcase
      frame_pos = 0;
    endfunction

    function mean_pixel_t window_mean(int unsigned p, int unsigned w, int unsigned h);
      int          x, y, r0, r1, c0, c1, r, c;
      int unsigned sr, sg, sb, cnt;
      logic [23:0] px;
      mean_pixel_t m;
      x  = p % w;
      y  = p / w;
      r0 = (y - HALF < 0) ? 0 : y - HALF;
      r1 = (y + HALF - 1 > int'(h) - 1) ? int'(h) - 1 : y + HALF - 1;
      c0 = (x - HALF < 0) ? 0 : x - HALF;
      c1 = (x + HALF - 1 > int'(w) - 1) ? int'(w) - 1 : x + HALF - 1;
      sr = 0;
      sg = 0;
      sb = 0;
      for (r = r0; r <= r1; r++) begin
        for (c = c0; c <= c1; c++) begin
          px = frame_px[r * w + c];
          sr += px[23:16];
          sg += px[15:8];
          sb += px[7:0];
        end
      end
      cnt     = (r1 - r0 + 1) * (c1 - c0 + 1);
      m.red   = PIX_W'(sr / cnt);
      m.green = PIX_W'(sg / cnt);
      m.blue  = PIX_W'(sb / cnt);
      m.last  = (p == w * h - 1);
      return m;
    endfunction

    function void note_beat(logic act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned w, h, total, lag, k;
      w     = clamp(width_reg, MAX_W);
      h     = clamp(height_reg, MAX_H);
      total = w * h;
      lag   = (HALF - 1) * (w + 1);
      if (frame_pos < total) begin
        if (act) return;
        frame_px[frame_pos] = {r, g, b};
      end
      k = frame_pos;
      frame_pos++;
      if (k < lag) return;
      owed_means.insert(owed_means.size(), window_mean(k - lag, w, h));
      if (k - lag >= total - 1) frame_pos = 0;
    endfunction

    function void check_result(mean_pixel_t got);
      mean_pixel_t want;
      if (owed_means.size() == 0) begin
        $display("%0t: result with none expected, actual %h", $time, got);
        errors++;
        return;
      end
      want = owed_means.pop_front();
      if (got.red !== want.red)
        $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
      if (got.green !== want.green)
        $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
      if (got.blue !== want.blue)
        $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
      if (got.last !== want.last)
        $display("%0t: last_pixel expected %0d actual %0d", $time, want.last, got.last);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #4 clk = ~clk;

  bmf_pix_in_if  pin();
  bmf_pix_out_if pout();
  bmf_cfg_if     cfg();

  rgb_box_mean_filter u_top (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pin),
    .pix_out (pout),
    .cfg     (cfg)
  );

  box_mean_scoreboard sb = new();

  // Random gaps on the pixel source and stalls on the result sink. Both
  // are switched per frame so some frames run with no idling at all, and
  // the closing stretch of the run turns them off for good.
  bit          quiet      = 1'b0;
  bit          in_gaps    = 1'b1;
  bit          out_stalls = 1'b1;
  int unsigned stall_left = 0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles;

  // The sink holds ready low for bursts of random length, started at random.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      pout.ready <= 1'b0;
    end else if (!quiet && out_stalls && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 10);
      pout.ready <= 1'b0;
    end else begin
      pout.ready <= 1'b1;
    end
  end

  // Every accepted result beat is checked against the oldest owed mean.
  always @(posedge clk) begin
    if (!rst && pout.valid && pout.ready)
      sb.check_result({pout.red_out, pout.green_out, pout.blue_out, pout.last_pixel});
  end

  // The run ends if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (pin.valid && pin.ready) || (pout.valid && pout.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // All driving tasks are entered right after a rising edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, val);
    cfg.valid <= 1'b0;
  endtask

  task automatic send_beat(input logic act, input logic [23:0] rgb);
    if (!quiet && in_gaps && $urandom_range(0, 5) == 0) begin
      pin.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    pin.valid    <= 1'b1;
    pin.action   <= act;
    pin.red_in   <= rgb[23:16];
    pin.green_in <= rgb[15:8];
    pin.blue_in  <= rgb[7:0];
    do @(posedge clk); while (!pin.ready);
    sb.note_beat(act, rgb[23:16], rgb[15:8], rgb[7:0]);
  endtask

  // Registers may only change once the block has nothing left in flight.
  task automatic settle();
    pin.valid <= 1'b0;
    while (sb.owed_means.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Sends one frame: its pixels, with early drain beats sprinkled in as
  // noise, then the drain beats that flush the lag. Some of the flushing
  // beats are extra pixels, which the block treats as drains. A frame cut
  // short is restarted by the next register write.
  task automatic run_frame(input logic [CFG_DATA_W-1:0] wval,
                           input logic [CFG_DATA_W-1:0] hval,
                           input int pattern, input bit cut_short);
    int unsigned w, h, total, lag, n, stop;
    write_reg(REG_IMAGE_WIDTH, wval);
    write_reg(REG_IMAGE_HEIGHT, hval);
    w     = sb.clamp(wval[WIDTH_REG_W-1:0], MAX_W);
    h     = sb.clamp(hval[HEIGHT_REG_W-1:0], MAX_H);
    total = w * h;
    lag   = (HALF - 1) * (w + 1);
    stop  = total + lag;
    if (cut_short) begin
      stop = $urandom_range(1, (stop - 1 < CUT_MAX) ? stop - 1 : CUT_MAX);
    end
    for (n = 0; n < stop; n++) begin
      if (n < total) begin
        if ($urandom_range(0, 9) == 0) send_beat(1'b1, 24'($urandom));
        case (pattern)
          0: send_beat(1'b0, 24'h000000);
          1: send_beat(1'b0, 24'hFFFFFF);
          2: send_beat(1'b0, (n % 2) ? 24'hFFFFFF : 24'h000000);
          default: send_beat(1'b0, 24'($urandom));
        endcase
      end else begin
        send_beat($urandom_range(0, 3) != 0, 24'($urandom));
      end
      items_sent++;
    end
    settle();
  endtask

  initial begin
    int unsigned i;
    pin.valid    <= 1'b0;
    pin.action   <= 1'b0;
    pin.red_in   <= '0;
    pin.green_in <= '0;
    pin.blue_in  <= '0;
    cfg.valid    <= 1'b0;
    cfg.index    <= '0;
    cfg.data     <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // At the reset size of 640 by 480 a few pixels give no result yet; the first
    // size register write after them throws that partial frame away.
    for (i = 0; i < 30; i++) begin
      send_beat(1'b0, 24'($urandom));
      items_sent++;
    end
    settle();

    // Writes to unused indexes must leave the frame alone.
    write_reg(REG_SPARE_A, 13'h1FFF);
    write_reg(REG_SPARE_B, 13'h0000);

    // Directed frames: single pixel, all-dark and all-bright, a checker
    // pattern, zero sizes acting as one, oversized values clamped, and the
    // maximum width, the last four cut short and checked over their opening part.
    run_frame(13'd1, 13'd1, 1, 1'b0);
    run_frame(13'd3, 13'd2, 0, 1'b0);
    run_frame(13'd12, 13'd11, 1, 1'b0);
    run_frame(13'd11, 13'd12, 2, 1'b0);
    run_frame(13'd0, 13'd4, 3, 1'b0);
    run_frame(13'd6, 13'd0, 3, 1'b0);
    run_frame(13'd7, 13'd9, 3, 1'b1);
    run_frame(13'h1FFF, 13'd1, 3, 1'b1);
    run_frame(13'd1, 13'h1FFF, 3, 1'b1);
    run_frame(13'd1024, 13'd1, 2, 1'b1);

    while (items_sent < ITEM_GOAL) begin
      in_gaps    = $urandom_range(0, 3) != 0;
      out_stalls = $urandom_range(0, 3) != 0;
      quiet      = items_sent > ITEM_GOAL - 250;
      run_frame(13'($urandom_range(1, 20)), 13'($urandom_range(1, 12)), 3,
                $urandom_range(0, 5) == 0);
    end

    if (sb.errors == 0 && sb.owed_means.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/bmf_pkg.sv
rtl/bmf_if.sv
rtl/bmf_ctrl.sv
rtl/bmf_dp.sv
rtl/rgb_box_mean_filter.sv
rtl/bmf_checker.sv
tb/rgb_box_mean_filter_tb.sv
